// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
// Depends on nothing; the includer supplies clock and active-low reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition is never true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/swm_pkg.sv =====
// Package of the sliding window maximum unit: default sizes, the window size
// register format and the command and status bundles between its controller and datapath.
package swm_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  localparam int              CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 7'd3;

  typedef struct packed {
    logic accept;
    logic rd_head;
    logic rd_tail;
    logic pop_head;
    logic pop_tail;
    logic push;
    logic load_out;
  } swm_cmd_t;

  typedef struct packed {
    logic empty;
    logic expired;
    logic dominated;
    logic emit;
    logic out_free;
  } swm_status_t;

endpackage

// ===== design/swm_ctrl.sv =====
// Controller of the sliding window maximum unit: steps one transaction through
// expiry, back removal, append and result load. Depends on swm_pkg.
module swm_ctrl
  import swm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  swm_status_t status_i,
  output swm_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RD_HEAD  = 3'd1;
  localparam logic [2:0] ST_CHK_HEAD = 3'd2;
  localparam logic [2:0] ST_RD_TAIL  = 3'd3;
  localparam logic [2:0] ST_CHK_TAIL = 3'd4;
  localparam logic [2:0] ST_WRITE    = 3'd5;
  localparam logic [2:0] ST_RD_OUT   = 3'd6;
  localparam logic [2:0] ST_LOAD     = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_RD_HEAD;
        end
      end
      ST_RD_HEAD: begin
        if (status_i.empty) begin
          state_d = ST_WRITE;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d       = ST_CHK_HEAD;
        end
      end
      ST_CHK_HEAD: begin
        if (status_i.expired) begin
          cmd_o.pop_head = 1'b1;
          state_d        = ST_RD_HEAD;
        end else begin
          state_d = ST_RD_TAIL;
        end
      end
      ST_RD_TAIL: begin
        if (status_i.empty) begin
          state_d = ST_WRITE;
        end else begin
          cmd_o.rd_tail = 1'b1;
          state_d       = ST_CHK_TAIL;
        end
      end
      ST_CHK_TAIL: begin
        if (status_i.dominated) begin
          cmd_o.pop_tail = 1'b1;
          state_d        = ST_RD_TAIL;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.push = 1'b1;
        state_d    = status_i.emit ? ST_RD_OUT : ST_IDLE;
      end
      ST_RD_OUT: begin
        cmd_o.rd_head = 1'b1;
        state_d       = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/swm_datapath.sv =====
// Datapath of the sliding window maximum unit: candidate memory, ring pointers,
// counters, window size register and output register. Depends on swm_pkg.
module swm_datapath
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [CFG_WIDTH-1:0]           cfg_wdata_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           start_new_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] window_max_o,
  input  swm_cmd_t                       cmd_i,
  output swm_status_t                    status_o
);

  localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int PW   = $clog2(2 * WINDOW_MAX);
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int CMPW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

  logic signed [SAMPLE_WIDTH-1:0] cand_value_mem [WINDOW_MAX];
  logic [PW-1:0]                  cand_pos_mem   [WINDOW_MAX];

  logic [CFG_WIDTH-1:0]           window_size_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic signed [SAMPLE_WIDTH-1:0] rd_value_q;
  logic [PW-1:0]                  rd_pos_q;
  logic [AW-1:0]                  head_q, tail_q;
  logic [CW-1:0]                  count_q, filled_q;
  logic [PW-1:0]                  pos_q;
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] window_max_q;

  logic [AW-1:0]   head_next, tail_prev, tail_next, rd_addr;
  logic [PW-1:0]   pos_next;
  logic [CW-1:0]   ws, filled_next;
  logic [CMPW-1:0] cfg_ext;
  logic [PW:0]     age;
  logic            full;

  assign head_next = (head_q == AW'(WINDOW_MAX - 1)) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == AW'(WINDOW_MAX - 1)) ? '0 : tail_q + 1'b1;
  assign tail_prev = (tail_q == '0) ? AW'(WINDOW_MAX - 1) : tail_q - 1'b1;
  assign pos_next  = (pos_q == PW'(2 * WINDOW_MAX - 1)) ? '0 : pos_q + 1'b1;
  assign rd_addr   = cmd_i.rd_tail ? tail_prev : head_q;

  assign cfg_ext = CMPW'(window_size_q);

  always_comb begin
    if (window_size_q == '0) begin
      ws = CW'(1);
    end else if (cfg_ext > CMPW'(WINDOW_MAX)) begin
      ws = CW'(WINDOW_MAX);
    end else begin
      ws = CW'(cfg_ext);
    end
  end

  always_comb begin
    if (pos_q >= rd_pos_q) begin
      age = {1'b0, pos_q} - {1'b0, rd_pos_q};
    end else begin
      age = {1'b0, pos_q} + (PW+1)'(2 * WINDOW_MAX) - {1'b0, rd_pos_q};
    end
  end

  assign filled_next = (filled_q == CW'(WINDOW_MAX)) ? filled_q : filled_q + 1'b1;
  assign full        = (count_q >= CW'(WINDOW_MAX));

  assign status_o.empty     = (count_q == '0);
  assign status_o.expired   = (age >= (PW+1)'(ws));
  assign status_o.dominated = (sample_q >= rd_value_q);
  assign status_o.emit      = (filled_next >= ws);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      cand_value_mem[tail_q] <= sample_q;
      cand_pos_mem[tail_q]   <= pos_q;
    end
    if (cmd_i.rd_head || cmd_i.rd_tail) begin
      rd_value_q <= cand_value_mem[rd_addr];
      rd_pos_q   <= cand_pos_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.load_out) begin
      window_max_q <= rd_value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= CFG_RESET;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      filled_q      <= '0;
      pos_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        window_size_q <= cfg_wdata_i;
      end
      if (cmd_i.accept && start_new_i) begin
        head_q   <= '0;
        tail_q   <= '0;
        count_q  <= '0;
        filled_q <= '0;
      end
      if (cmd_i.pop_head) begin
        head_q  <= head_next;
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.pop_tail) begin
        tail_q  <= tail_prev;
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.push) begin
        tail_q   <= tail_next;
        pos_q    <= pos_next;
        filled_q <= filled_next;
        if (full) begin
          head_q <= head_next;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = window_max_q;

endmodule

// ===== design/sliding_window_maximum_unit.sv =====
// Sliding window maximum unit: signed samples in, maximum of the last
// window_size samples out, kept with a monotonic deque of candidates.
// Channels: cfg (valid/ready, 7-bit window size, always ready), in (sample_i
// and start_new_i under in_valid_i/in_ready_o), out (window_max_o under
// out_valid_o/out_ready_i). Each transaction is handled one at a time; the
// candidate memory has a single read port, so every examined candidate is first
// read into a register and then compared. A sample is taken in, expired candidates
// are removed at the front and dominated ones at the back, the sample is appended,
// and when a result is due the front candidate is read and loaded into the
// output register.
// No result appears until window_size samples have arrived since the last
// transaction with start_new_i set. Reset empties the deque, clears all
// counters and sets the window size to 3; the candidate memory is not cleared.
// A result waits in the output register while the next item is taken in; if
// the receiver still stalls when the next result is ready, the block holds.
module sliding_window_maximum_unit
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_WIDTH-1:0]           cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           start_new_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] window_max_o
);

  swm_cmd_t    cmd;
  swm_status_t status;

  assign cfg_ready_o = 1'b1;

  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swm_datapath #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (sample_i),
    .start_new_i  (start_new_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .window_max_o (window_max_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

// ===== design/swm_checker.sv =====
// Port-level checker of the sliding window maximum unit and its bind statement.
// Depends on swm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swm_checker
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_ready_o,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] window_max_o
);

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `ASSERT_PROP(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(window_max_o), "result changed while stalled")
  `ASSERT_PROP(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "input taken while busy")
  `ASSERT_PROP(a_result_while_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(!in_ready_o), "result without a transaction in work")
  `ASSERT_NEVER(a_cfg_ready, clk_i, rst_ni, !cfg_ready_o, "configuration port not ready")

endmodule

bind sliding_window_maximum_unit swm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_ready_o  (cfg_ready_o),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .window_max_o (window_max_o)
);

// ===== tb/sv/sliding_window_maximum_unit_test.sv =====
// Testbench of the sliding window maximum unit: a directed table of expected maxima, then
// random streams under several window sizes and idle patterns, checked by a deque model.
// Depends on swm_pkg and sliding_window_maximum_unit only.
module sliding_window_maximum_unit_test;
  import swm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int DRAIN_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 104;
  localparam int NUM_PHASES = 13;
  localparam int NUM_ROWS = 25;
  localparam int AWAIT_DEPTH = 2048;
  localparam longint S_MIN = -64'sd2147483648;
  localparam longint S_MAX = 64'sd2147483647;

  typedef enum int {RUN_RANDOM, RUN_NARROW, RUN_FALLING, RUN_RISING, RUN_EXTREME} run_kind_e;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 start;
    bit                   typed;
    bit                   emits;
    logic signed [SW-1:0] max;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_WIDTH-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [SW-1:0] sample_i = '0;
  logic                 start_new_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [SW-1:0] window_max_o;

  sliding_window_maximum_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .start_new_i  (start_new_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .window_max_o (window_max_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Deque model state.
  logic signed [SW-1:0] cand_val [64];
  logic [6:0]           cand_pos [64];
  logic [5:0]           front_idx = '0;
  logic [5:0]           free_idx = '0;
  int unsigned          live_count = 0;
  logic [6:0]           arrival_pos = '0;
  int unsigned          since_start = 0;
  logic [CFG_WIDTH-1:0] window_reg = CFG_RESET;

  logic signed [SW-1:0] awaited_max [AWAIT_DEPTH];
  int                   await_wr = 0;
  int                   await_rd = 0;
  int                   mismatch_count = 0;
  int                   samples_sent = 0;
  int                   markers_sent = 0;
  int                   maxima_seen = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  longint               run_level;

  function automatic bit deque_step(input logic signed [SW-1:0] s, input logic st,
                                    output logic signed [SW-1:0] mx);
    int unsigned ws;
    logic [6:0]  age;
    logic [5:0]  back;
    if (st) begin
      front_idx = '0;
      free_idx = '0;
      live_count = 0;
      since_start = 0;
    end
    ws = (window_reg == 0) ? 1 : (window_reg > 64) ? 64 : window_reg;
    while (live_count > 0) begin
      age = arrival_pos - cand_pos[front_idx];
      if (age < ws) break;
      front_idx++;
      live_count--;
    end
    while (live_count > 0) begin
      back = free_idx - 6'd1;
      if (s < cand_val[back]) break;
      free_idx = back;
      live_count--;
    end
    if (live_count >= 64) begin
      front_idx++;
      live_count--;
    end
    cand_val[free_idx] = s;
    cand_pos[free_idx] = arrival_pos;
    free_idx++;
    live_count++;
    arrival_pos++;
    if (since_start < 64) since_start++;
    mx = cand_val[front_idx];
    return since_start >= ws;
  endfunction

  function automatic logic signed [SW-1:0] next_sample(input run_kind_e kind);
    longint v;
    case (kind)
      RUN_RANDOM: v = $signed($urandom);
      RUN_NARROW: v = longint'($urandom_range(8)) - 4;
      RUN_FALLING: begin
        v = run_level - longint'($urandom_range(40));
        if (v < S_MIN) v = S_MIN;
      end
      RUN_RISING: begin
        v = run_level + longint'($urandom_range(40));
        if (v > S_MAX) v = S_MAX;
      end
      default: begin
        case ($urandom_range(4))
          0: v = S_MIN;
          1: v = S_MAX;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
    endcase
    run_level = v;
    return v[SW-1:0];
  endfunction

  task automatic send_sample(input logic signed [SW-1:0] s, input logic st, input bit typed,
                             input bit t_emits, input logic signed [SW-1:0] t_max);
    logic signed [SW-1:0] mx;
    bit                   emits;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    start_new_i <= st;
    do @(posedge clk_i); while (!in_ready_o);
    emits = deque_step(s, st, mx);
    if (typed) begin
      emits = t_emits;
      mx = t_max;
    end
    if (emits) begin
      awaited_max[await_wr % AWAIT_DEPTH] = mx;
      await_wr++;
    end
    samples_sent++;
    if (st) markers_sent++;
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_results();
    while (await_wr != await_rd) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [CFG_WIDTH-1:0] w);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    window_reg = w;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      maxima_seen++;
      if (await_wr == await_rd) begin
        $error("window_max: no result expected, actual %0d", window_max_o);
        mismatch_count++;
      end else begin
        if (window_max_o !== awaited_max[await_rd % AWAIT_DEPTH]) begin
          $error("window_max: expected %0d, actual %0d", awaited_max[await_rd % AWAIT_DEPTH],
                 window_max_o);
          mismatch_count++;
        end
        await_rd++;
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("sliding_window_maximum_unit_test: done, errors");
    $finish;
  end

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{-32'sd5, 1'b0, 1'b1, 1'b0, 32'sd0},
    '{32'sd7, 1'b0, 1'b1, 1'b0, 32'sd0},
    '{32'sd3, 1'b0, 1'b1, 1'b1, 32'sd7},
    '{32'sh80000000, 1'b0, 1'b1, 1'b1, 32'sd7},
    '{32'sh7FFFFFFF, 1'b0, 1'b1, 1'b1, 32'sh7FFFFFFF},
    '{32'sh7FFFFFFF, 1'b0, 1'b1, 1'b1, 32'sh7FFFFFFF},
    '{32'sd0, 1'b0, 1'b1, 1'b1, 32'sh7FFFFFFF},
    '{-32'sd1, 1'b0, 1'b1, 1'b1, 32'sh7FFFFFFF},
    '{-32'sd1, 1'b0, 1'b1, 1'b1, 32'sd0},
    '{-32'sd1, 1'b0, 1'b1, 1'b1, -32'sd1},
    '{32'sd100, 1'b1, 1'b1, 1'b0, 32'sd0},
    '{32'sd50, 1'b0, 1'b1, 1'b0, 32'sd0},
    '{32'sd25, 1'b0, 1'b1, 1'b1, 32'sd100},
    '{32'sd10, 1'b0, 1'b1, 1'b1, 32'sd50},
    '{32'sh80000000, 1'b0, 1'b1, 1'b1, 32'sd25},
    '{32'sh80000000, 1'b1, 1'b1, 1'b0, 32'sd0},
    '{32'sh80000000, 1'b0, 1'b1, 1'b0, 32'sd0},
    '{32'sh80000000, 1'b0, 1'b1, 1'b1, 32'sh80000000},
    '{32'sd1, 1'b1, 1'b1, 1'b0, 32'sd0},
    '{32'sd2, 1'b0, 1'b1, 1'b0, 32'sd0},
    '{32'sd3, 1'b0, 1'b1, 1'b1, 32'sd3},
    '{32'sd2, 1'b0, 1'b1, 1'b1, 32'sd3},
    '{32'sd1, 1'b0, 1'b1, 1'b1, 32'sd3},
    '{32'sd0, 1'b0, 1'b1, 1'b1, 32'sd2},
    '{32'sh12345678, 1'b0, 1'b0, 1'b0, 32'sd0}
  };

  logic [CFG_WIDTH-1:0] window_plan [NUM_PHASES-1] = '{
    7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd5, 7'd64, 7'd17, 7'd33, 7'd1, 7'd100, 7'd9
  };

  initial begin
    logic [CFG_WIDTH-1:0] ws;
    run_kind_e            kind;
    int                   run_len;
    int                   sent;
    bit                   fresh;
    logic                 st;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The reset window size of three applies to the whole table.
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_sample(directed_rows[r].sample, directed_rows[r].start, directed_rows[r].typed,
                  directed_rows[r].emits, directed_rows[r].max);
    end
    hold_input();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      ws = (ph < NUM_PHASES - 1) ? window_plan[ph] : CFG_WIDTH'($urandom_range(1, 64));
      write_window(ws);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = run_kind_e'($urandom_range(RUN_EXTREME));
        run_len = $urandom_range(1, 80);
        run_level = $signed($urandom);
        fresh = ($urandom_range(3) == 0);
        for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
          st = (k == 0 && fresh) || ($urandom_range(99) == 0);
          if (ph % 3 == 1 && sent == PHASE_ITEMS / 2) begin
            hold_input();
            wait_results();
          end
          send_sample(next_sample(kind), st, 1'b0, 1'b0, '0);
          sent++;
        end
      end
      hold_input();
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d samples with %0d start markers over %0d window settings.",
             samples_sent, markers_sent, NUM_PHASES + 1);
    $display("Checked %0d window maxima under four idle and stall patterns.", maxima_seen);
    if (mismatch_count == 0) begin
      $display("sliding_window_maximum_unit_test: done, clean");
    end else begin
      $display("sliding_window_maximum_unit_test: done, errors");
    end
    $finish;
  end

endmodule
